FILE: rtl/bltf_pkg.sv
// Package with the shared types and constants of the bilinear texel filter and blend block.
package bltf_pkg;

    // Register indexes on the configuration port.
    localparam logic REG_FILTERED   = 1'b0;
    localparam logic REG_BLEND_MODE = 1'b1;

    // Blend modes. The unused code behaves as a plain blend.
    localparam logic [1:0] MODE_PLAIN        = 2'd0;
    localparam logic [1:0] MODE_TEST_BLEND   = 2'd1;
    localparam logic [1:0] MODE_TEST_NOBLEND = 2'd2;

    localparam int unsigned NUM_TEXELS = 4;
    localparam int unsigned NUM_CHANS  = 4;

    localparam logic [8:0]  FRAC_ONE     = 9'd256;
    localparam logic [7:0]  SNAP_LIMIT   = 8'd127;
    localparam logic [16:0] WEIGHT_ROUND = 17'd128;
    localparam logic [7:0]  ALPHA_TEST   = 8'd128;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

    // Payload after the weight stage.
    typedef struct packed {
        logic [NUM_TEXELS-1:0][31:0] texel;
        logic [NUM_TEXELS-1:0][8:0]  weight;
        logic [31:0]                 background;
        logic                        sample_valid;
    } t_weighted;

    // Payload after the filter stage.
    typedef struct packed {
        logic [31:0] color;
        logic [31:0] background;
        logic        sample_valid;
    } t_filtered;

endpackage

FILE: rtl/bltf_weights.sv
// First pipeline stage: fraction snapping and the four rounded bilinear weights.
module bltf_weights (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic                    i_filtered,
    input  logic [31:0]             i_texel_a,
    input  logic [31:0]             i_texel_b,
    input  logic [31:0]             i_texel_c,
    input  logic [31:0]             i_texel_d,
    input  logic [7:0]              i_frac_x,
    input  logic [7:0]              i_frac_y,
    input  logic [31:0]             i_background,
    input  logic                    i_sample_valid,
    output logic                    o_valid,
    output bltf_pkg::t_weighted     o_data
);

    logic                r_valid;
    bltf_pkg::t_weighted r_data;
    bltf_pkg::t_weighted n_data;

    logic [8:0]  fx, fy, ix, iy;
    logic [16:0] p0, p1, p2, p3;
    logic [16:0] s0, s1, s2, s3;

    always_comb begin
        if (i_filtered) begin
            fx = {1'b0, i_frac_x};
            fy = {1'b0, i_frac_y};
        end else begin
            fx = (i_frac_x <= bltf_pkg::SNAP_LIMIT) ? 9'd0 : bltf_pkg::FRAC_ONE;
            fy = (i_frac_y <= bltf_pkg::SNAP_LIMIT) ? 9'd0 : bltf_pkg::FRAC_ONE;
        end
        ix = bltf_pkg::FRAC_ONE - fx;
        iy = bltf_pkg::FRAC_ONE - fy;
        p0 = 17'(ix * iy);
        p1 = 17'(fx * iy);
        p2 = 17'(ix * fy);
        p3 = 17'(fx * fy);
        s0 = p0 + bltf_pkg::WEIGHT_ROUND;
        s1 = p1 + bltf_pkg::WEIGHT_ROUND;
        s2 = p2 + bltf_pkg::WEIGHT_ROUND;
        s3 = p3 + bltf_pkg::WEIGHT_ROUND;

        n_data.texel[0]     = i_texel_a;
        n_data.texel[1]     = i_texel_b;
        n_data.texel[2]     = i_texel_c;
        n_data.texel[3]     = i_texel_d;
        n_data.weight[0]    = s0[16:8];
        n_data.weight[1]    = s1[16:8];
        n_data.weight[2]    = s2[16:8];
        n_data.weight[3]    = s3[16:8];
        n_data.background   = i_background;
        n_data.sample_valid = i_sample_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/bltf_filter.sv
// Second pipeline stage: weighted sum of the four texels in each channel.
module bltf_filter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  bltf_pkg::t_weighted     i_data,
    output logic                    o_valid,
    output bltf_pkg::t_filtered     o_data
);

    logic                r_valid;
    bltf_pkg::t_filtered r_data;
    bltf_pkg::t_filtered n_data;

    logic [bltf_pkg::NUM_CHANS-1:0][17:0] sum;

    // The rounded weights can add up past 256; the channel then wraps to its low 8 bits.
    always_comb begin
        for (int k = 0; k < bltf_pkg::NUM_CHANS; k++) begin
            sum[k] = 18'd0;
            for (int i = 0; i < bltf_pkg::NUM_TEXELS; i++) begin
                sum[k] = sum[k] + 18'(i_data.texel[i][8*k +: 8] * i_data.weight[i]);
            end
            n_data.color[8*k +: 8] = sum[k][15:8];
        end
        n_data.background   = i_data.background;
        n_data.sample_valid = i_data.sample_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/bltf_blend.sv
// Third pipeline stage: alpha test, blend against the background, output register.
module bltf_blend (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [1:0]              i_blend_mode,
    input  bltf_pkg::t_filtered     i_data,
    output logic                    o_valid,
    output logic [31:0]             o_pixel
);

    logic        r_valid;
    logic [31:0] r_pixel;
    logic [31:0] n_pixel;

    logic [7:0]  alpha;
    logic [8:0]  inv_alpha;
    logic        alpha_test;
    logic [31:0] mixed;
    logic [bltf_pkg::NUM_CHANS-1:0][15:0] mix_sum;

    always_comb begin
        alpha      = i_data.color[31:24];
        inv_alpha  = bltf_pkg::FRAC_ONE - {1'b0, alpha};
        alpha_test = (i_blend_mode == bltf_pkg::MODE_TEST_BLEND) ||
                     (i_blend_mode == bltf_pkg::MODE_TEST_NOBLEND);

        for (int k = 0; k < bltf_pkg::NUM_CHANS; k++) begin
            mix_sum[k] = 16'(i_data.background[8*k +: 8] * inv_alpha) +
                         16'(i_data.color[8*k +: 8] * alpha);
            mixed[8*k +: 8] = mix_sum[k][15:8];
        end

        if (!i_data.sample_valid) begin
            n_pixel = i_data.background;
        end else if (alpha_test && (alpha < bltf_pkg::ALPHA_TEST)) begin
            n_pixel = i_data.background;
        end else if (i_blend_mode == bltf_pkg::MODE_TEST_NOBLEND) begin
            n_pixel = {bltf_pkg::ALPHA_OPAQUE, i_data.color[23:0]};
        end else if (alpha == bltf_pkg::ALPHA_OPAQUE) begin
            n_pixel = i_data.color;
        end else begin
            n_pixel = mixed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

endmodule

FILE: rtl/bilinear_texel_filter_blend_top.sv
// Top level of the bilinear texel filter with alpha blend.
//
// The block takes one sample per clock while the output side takes results (four
// BGRA texels, two 8-bit fractions, a background pixel and a valid flag) and gives
// one destination pixel per sample. The work runs in three register stages: the
// first snaps the fractions when filtering is off and forms the four rounded 1.8
// weights, the second multiplies and sums the texels per channel, and the third
// performs the alpha test and the background blend into the output register. All
// stages move together; a stage holds its contents while the output is stalled,
// so o_in_ready is high whenever the output register is empty or being taken, and
// a new sample can follow in every cycle. Configuration (filtered and blend_mode)
// goes through the plain write port; the user must write it only while no sample
// is in flight, which the block itself does not enforce. Both registers reset to
// zero.
module bilinear_texel_filter_blend_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [1:0]  i_cfg_data,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_texel_a,
    input  logic [31:0] i_texel_b,
    input  logic [31:0] i_texel_c,
    input  logic [31:0] i_texel_d,
    input  logic [7:0]  i_frac_x,
    input  logic [7:0]  i_frac_y,
    input  logic [31:0] i_background,
    input  logic        i_sample_valid,
    // Output channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_pixel
);

    logic       r_filtered;
    logic [1:0] r_blend_mode;

    // Pipeline advance: the output register is free or its transfer completes now.
    logic en;

    logic                w_valid;
    bltf_pkg::t_weighted w_data;
    logic                f_valid;
    bltf_pkg::t_filtered f_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filtered   <= 1'b0;
            r_blend_mode <= bltf_pkg::MODE_PLAIN;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == bltf_pkg::REG_FILTERED) begin
                r_filtered <= i_cfg_data[0];
            end else begin
                r_blend_mode <= i_cfg_data;
            end
        end
    end

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    bltf_weights u_weights (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en),
        .i_valid        (i_in_valid),
        .i_filtered     (r_filtered),
        .i_texel_a      (i_texel_a),
        .i_texel_b      (i_texel_b),
        .i_texel_c      (i_texel_c),
        .i_texel_d      (i_texel_d),
        .i_frac_x       (i_frac_x),
        .i_frac_y       (i_frac_y),
        .i_background   (i_background),
        .i_sample_valid (i_sample_valid),
        .o_valid        (w_valid),
        .o_data         (w_data)
    );

    bltf_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_valid),
        .i_data  (w_data),
        .o_valid (f_valid),
        .o_data  (f_data)
    );

    bltf_blend u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (f_valid),
        .i_blend_mode (r_blend_mode),
        .i_data       (f_data),
        .o_valid      (o_out_valid),
        .o_pixel      (o_pixel)
    );

endmodule

FILE: rtl/bltf_checker.sv
// Port-level checker for the bilinear texel filter and blend block, with its bind.
module bltf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_pixel
);

    // A stalled result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_pixel)))
        else $error("stalled result changed");

    // The input side is never blocked while the output register is free.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input not ready while output free");

    // The input side is held off while a result waits.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input ready while output stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result present after reset");

    // A transfer into an empty, running pipeline reaches the output through the weight, filter and blend registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_out_ready) ##1 i_out_ready ##1 i_out_ready
        |=> o_out_valid)
        else $error("result missing after three cycles");

endmodule

bind bilinear_texel_filter_blend_top bltf_checker u_bltf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pixel     (o_pixel)
);
